@@ design/tt_pkg.sv @@
package tt_pkg;

    localparam int SLOT_BYTES = 32;

    localparam logic [1:0] OP_TEXT     = 2'd0;
    localparam logic [1:0] OP_KW_WRITE = 2'd1;
    localparam logic [1:0] OP_END      = 2'd2;

    localparam logic [2:0] TYPE_WORD    = 3'd0;
    localparam logic [2:0] TYPE_KEYWORD = 3'd1;
    localparam logic [2:0] TYPE_STRING  = 3'd2;
    localparam logic [2:0] TYPE_SYMBOL  = 3'd3;
    localparam logic [2:0] TYPE_END     = 3'd4;

    localparam logic [2:0] REG_SYMBOL_SET_0  = 3'd0;
    localparam logic [2:0] REG_SYMBOL_SET_1  = 3'd1;
    localparam logic [2:0] REG_SYMBOL_SET_2  = 3'd2;
    localparam logic [2:0] REG_SYMBOL_SET_3  = 3'd3;
    localparam logic [2:0] REG_KEYWORD_COUNT = 3'd4;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] text_byte;
        logic [3:0] keyword_slot;
        logic [4:0] keyword_position;
        logic [7:0] keyword_byte;
    } text_item_t;

    typedef struct packed {
        logic [2:0] token_type;
        logic [7:0] content_byte;
        logic [5:0] content_length;
        logic       byte_last;
        logic       truncated;
    } token_item_t;

endpackage

@@ design/tt_ram.sv @@
module tt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/text_tokenizer_unit.sv @@
// channel   direction  beat
// text      in         tt_pkg::text_item_t  (text byte, keyword write, end of text)
// token     out        tt_pkg::token_item_t (one content byte of a token)
// cfg       in         cfg_index / cfg_data register write
//
// A keyword write, a stored byte or a blank or quote with nothing pending stays idle.
// A token is emitted byte by byte: ST_EM_RD reads the buffer, ST_EM_OUT sends it.
// Keyword lookup uses one compare unit: ST_KW_RD, ST_KW_CMP per byte, slot after slot.
// After reset a clearing pass zeroes the keyword store (KEYWORD_SLOTS*32 bytes);
// text is not taken meanwhile, cfg writes are. A stalled token beat holds the sequencer.
module text_tokenizer_unit #(
    parameter int MAX_TOKEN_BYTES = 32,
    parameter int KEYWORD_SLOTS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_ready,
    input  tt_pkg::text_item_t  text_item,
    output logic                tok_valid,
    input  logic                tok_ready,
    output tt_pkg::token_item_t tok_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import tt_pkg::*;

    localparam int BA = $clog2(MAX_TOKEN_BYTES);
    localparam int FW = $clog2(MAX_TOKEN_BYTES + 1);
    localparam int KW_DEPTH = KEYWORD_SLOTS * SLOT_BYTES;
    localparam int KA = $clog2(KW_DEPTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_KW_RD  = 3'd1;
    localparam logic [2:0] ST_KW_CMP = 3'd2;
    localparam logic [2:0] ST_EM_RD  = 3'd3;
    localparam logic [2:0] ST_EM_OUT = 3'd4;
    localparam logic [2:0] ST_TAIL   = 3'd5;

    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_SYM  = 2'd1;
    localparam logic [1:0] TAIL_END  = 2'd2;

    logic [2:0]    state_reg, state_next;
    logic [63:0]   sym_reg [4];
    logic [63:0]   sym_next [4];
    logic [4:0]    kw_count_reg, kw_count_next;
    logic          mode_reg, mode_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic          pbs_reg, pbs_next;
    logic [1:0]    tail_reg, tail_next;
    logic [2:0]    type_reg, type_next;
    logic [7:0]    sym_byte_reg, sym_byte_next;
    logic [FW-1:0] em_idx_reg, em_idx_next;
    logic [6:0]    slot_reg, slot_next;
    logic [5:0]    idx_reg, idx_next;
    logic          clearing_reg, clearing_next;
    logic [KA-1:0] clr_addr_reg, clr_addr_next;
    logic          tok_valid_reg, tok_valid_next;
    token_item_t   tok_item_reg, tok_item_next;

    logic          buf_we;
    logic [BA-1:0] buf_waddr, buf_raddr;
    logic [7:0]    buf_wdata, buf_rdata;
    logic          kw_we;
    logic [KA-1:0] kw_waddr, kw_raddr;
    logic [7:0]    kw_wdata, kw_rdata;

    logic [6:0] cnt_eff;
    logic       accept, do_flush, is_sym, is_ws, out_free, em_last, kw_ok, kw_done;
    logic [7:0] b;

    tt_ram #(.WIDTH(8), .DEPTH(MAX_TOKEN_BYTES)) u_buf (
        .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
        .raddr(buf_raddr), .rdata(buf_rdata)
    );

    tt_ram #(.WIDTH(8), .DEPTH(KW_DEPTH)) u_kw (
        .clk(clk), .we(kw_we), .waddr(kw_waddr), .wdata(kw_wdata),
        .raddr(kw_raddr), .rdata(kw_rdata)
    );

    assign text_ready = (state_reg == ST_IDLE) && !clearing_reg;
    assign cfg_ready  = 1'b1;
    assign tok_valid  = tok_valid_reg;
    assign tok_item   = tok_item_reg;

    assign accept   = text_valid && text_ready;
    assign b        = text_item.text_byte;
    assign is_sym   = sym_reg[b[7:6]][b[5:0]];
    assign is_ws    = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NEWLINE);
    assign out_free = !tok_valid_reg || tok_ready;
    assign cnt_eff  = (7'(kw_count_reg) > 7'(KEYWORD_SLOTS)) ? 7'(KEYWORD_SLOTS)
                                                            : 7'(kw_count_reg);
    assign em_last  = (fill_reg == '0) || (em_idx_reg == FW'(fill_reg - 1'b1));

    assign buf_raddr = (state_reg == ST_KW_RD || state_reg == ST_KW_CMP) ? BA'(idx_reg)
                                                                          : BA'(em_idx_reg);
    assign kw_raddr  = KA'((32'(slot_reg) << 5) + 32'(idx_reg[4:0]));

    // bytes below fill must match and be nonzero; the keyword ends at fill
    always_comb
    begin
        if (7'(idx_reg) < 7'(fill_reg))
        begin
            kw_ok   = (kw_rdata == buf_rdata) && (kw_rdata != 8'd0);
            kw_done = (7'(fill_reg) == 7'(SLOT_BYTES)) && (7'(idx_reg) == 7'(fill_reg) - 7'd1);
        end
        else
        begin
            kw_ok   = (kw_rdata == 8'd0);
            kw_done = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        kw_count_next  = kw_count_reg;
        mode_next      = mode_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        pbs_next       = pbs_reg;
        tail_next      = tail_reg;
        type_next      = type_reg;
        sym_byte_next  = sym_byte_reg;
        em_idx_next    = em_idx_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        tok_valid_next = tok_valid_reg;
        tok_item_next  = tok_item_reg;
        buf_we         = 1'b0;
        buf_waddr      = BA'(fill_reg);
        buf_wdata      = b;
        kw_we          = 1'b0;
        kw_waddr       = KA'((32'(text_item.keyword_slot) << 5)
                             + 32'(text_item.keyword_position));
        kw_wdata       = text_item.keyword_byte;
        do_flush       = 1'b0;

        if (tok_valid_reg && tok_ready)
        begin
            tok_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index <= REG_SYMBOL_SET_3)
            begin
                sym_next[cfg_index[1:0]] = cfg_data;
            end
            else if (cfg_index == REG_KEYWORD_COUNT)
            begin
                kw_count_next = cfg_data[4:0];
            end
        end

        if (clearing_reg)
        begin
            kw_we         = 1'b1;
            kw_waddr      = clr_addr_reg;
            kw_wdata      = 8'd0;
            clr_addr_next = clr_addr_reg + 1'b1;
            if (32'(clr_addr_reg) == KW_DEPTH - 1)
            begin
                clearing_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (text_item.operation)
                        OP_KW_WRITE:
                        begin
                            if (7'(text_item.keyword_slot) < 7'(KEYWORD_SLOTS))
                            begin
                                kw_we = 1'b1;
                            end
                        end
                        OP_END:
                        begin
                            tail_next = TAIL_END;
                            mode_next = 1'b0;
                            if (mode_reg)
                            begin
                                type_next   = TYPE_STRING;
                                em_idx_next = '0;
                                state_next  = ST_EM_RD;
                            end
                            else
                            begin
                                do_flush = 1'b1;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (mode_reg)
                            begin
                                if (b == CHAR_QUOTE)
                                begin
                                    if (pbs_reg)
                                    begin
                                        // escaped quote overwrites the stored backslash
                                        if (!ovf_reg && fill_reg != '0)
                                        begin
                                            buf_we    = 1'b1;
                                            buf_waddr = BA'(fill_reg - 1'b1);
                                            buf_wdata = CHAR_QUOTE;
                                        end
                                        pbs_next = 1'b0;
                                    end
                                    else
                                    begin
                                        type_next   = TYPE_STRING;
                                        tail_next   = TAIL_NONE;
                                        mode_next   = 1'b0;
                                        em_idx_next = '0;
                                        state_next  = ST_EM_RD;
                                    end
                                end
                                else
                                begin
                                    if (32'(fill_reg) < MAX_TOKEN_BYTES)
                                    begin
                                        buf_we    = 1'b1;
                                        fill_next = fill_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    pbs_next = (b == CHAR_BACKSLASH);
                                end
                            end
                            else if (b == CHAR_QUOTE)
                            begin
                                tail_next = TAIL_NONE;
                                mode_next = 1'b1;
                                do_flush  = 1'b1;
                            end
                            else if (is_sym)
                            begin
                                tail_next     = TAIL_SYM;
                                sym_byte_next = b;
                                do_flush      = 1'b1;
                            end
                            else if (is_ws)
                            begin
                                tail_next = TAIL_NONE;
                                do_flush  = 1'b1;
                            end
                            else if (32'(fill_reg) < MAX_TOKEN_BYTES)
                            begin
                                buf_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_flush)
                    begin
                        em_idx_next = '0;
                        slot_next   = '0;
                        idx_next    = '0;
                        type_next   = TYPE_WORD;
                        if (fill_reg != '0 || ovf_reg)
                        begin
                            if (ovf_reg || 7'(fill_reg) > 7'(SLOT_BYTES) || cnt_eff == 7'd0)
                            begin
                                state_next = ST_EM_RD;
                            end
                            else
                            begin
                                state_next = ST_KW_RD;
                            end
                        end
                        else
                        begin
                            fill_next  = '0;
                            ovf_next   = 1'b0;
                            pbs_next   = 1'b0;
                            state_next = (tail_next == TAIL_NONE) ? ST_IDLE : ST_TAIL;
                        end
                    end
                end
            end
            ST_KW_RD:
            begin
                state_next = ST_KW_CMP;
            end
            ST_KW_CMP:
            begin
                if (kw_ok && kw_done)
                begin
                    type_next  = TYPE_KEYWORD;
                    state_next = ST_EM_RD;
                end
                else if (kw_ok)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_KW_RD;
                end
                else if (slot_reg + 7'd1 == cnt_eff)
                begin
                    state_next = ST_EM_RD;
                end
                else
                begin
                    slot_next  = slot_reg + 7'd1;
                    idx_next   = '0;
                    state_next = ST_KW_RD;
                end
            end
            ST_EM_RD:
            begin
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                if (out_free)
                begin
                    tok_valid_next               = 1'b1;
                    tok_item_next.token_type     = type_reg;
                    tok_item_next.content_byte   = (fill_reg == '0) ? 8'd0 : buf_rdata;
                    tok_item_next.content_length = 6'(fill_reg);
                    tok_item_next.byte_last      = em_last;
                    tok_item_next.truncated      = ovf_reg;
                    if (em_last)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        pbs_next   = 1'b0;
                        state_next = (tail_reg == TAIL_NONE) ? ST_IDLE : ST_TAIL;
                    end
                    else
                    begin
                        em_idx_next = em_idx_reg + 1'b1;
                        state_next  = ST_EM_RD;
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    tok_valid_next = 1'b1;
                    tok_item_next.byte_last = 1'b1;
                    tok_item_next.truncated = 1'b0;
                    if (tail_reg == TAIL_SYM)
                    begin
                        tok_item_next.token_type     = TYPE_SYMBOL;
                        tok_item_next.content_byte   = sym_byte_reg;
                        tok_item_next.content_length = 6'd1;
                    end
                    else
                    begin
                        tok_item_next.token_type     = TYPE_END;
                        tok_item_next.content_byte   = 8'd0;
                        tok_item_next.content_length = 6'd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sym_reg       <= '{default: '0};
            kw_count_reg  <= '0;
            mode_reg      <= 1'b0;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            pbs_reg       <= 1'b0;
            tail_reg      <= TAIL_NONE;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sym_reg       <= sym_next;
            kw_count_reg  <= kw_count_next;
            mode_reg      <= mode_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            pbs_reg       <= pbs_next;
            tail_reg      <= tail_next;
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        sym_byte_reg <= sym_byte_next;
        em_idx_reg   <= em_idx_next;
        slot_reg     <= slot_next;
        idx_reg      <= idx_next;
        tok_item_reg <= tok_item_next;
    end
endmodule
